### rtl/murmur3_32_hash_unit_macros.svh
// Assertion shorthands used by the checker file.
`ifndef MURMUR3_32_HASH_UNIT_MACROS_SVH
`define MURMUR3_32_HASH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define M3H_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("m3h check failed");

// Next-cycle implication, disabled while reset is held.
`define M3H_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("m3h check failed");

`endif

### rtl/m3h_pkg.sv
`timescale 1ns / 1ps

package m3h_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 3;

  localparam logic [CountW-1:0] CountFull = 3'd4;

  localparam logic [WordW-1:0] MulC1 = 32'hcc9e2d51;
  localparam logic [WordW-1:0] MulC2 = 32'h1b873593;
  localparam logic [WordW-1:0] FoldN = 32'he6546b64;
  localparam logic [WordW-1:0] MixF1 = 32'h85ebca6b;
  localparam logic [WordW-1:0] MixF2 = 32'hc2b2ae35;

  // Queue depth between the front and the back; 2 or more.
  localparam int QueueDepth = 4;

  // One classified key word: masked data, its effective byte count and the last flag.
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              last;
  } item_t;

  typedef struct packed {
    logic  en;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

### rtl/murmur3_32_hash_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Beat payload
// in_       input      in_valid/in_stall   data_word[31:0], byte_count[2:0], last
// out_      output     out_valid/out_stall hash_value[31:0]
// cfg_      input      cfg_valid/cfg_ready seed[31:0]
//
// The back end runs each word through two registered multiplies and a fold (MUL1, MUL2,
// FOLD), and each key through two finalizer multiplies and an output load (FMIX1, FMIX2, FIN).
// The front takes beats into a QUEUE_DEPTH-entry queue while the back works.
// Reset is synchronous and active low; the seed resets to zero, no clearing pass.
// A stalled result holds in the output register; the back waits there, then the queue fills.
module murmur3_32_hash_unit #(
  parameter int QUEUE_DEPTH = m3h_pkg::QueueDepth
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [m3h_pkg::WordW-1:0]  in_data_word,
  input  logic [m3h_pkg::CountW-1:0] in_byte_count,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [m3h_pkg::WordW-1:0]  out_hash_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [m3h_pkg::WordW-1:0]  cfg_seed
);

  m3h_pkg::push_t  push;
  m3h_pkg::qhead_t head;
  logic            q_full;
  logic            pop;

  assign cfg_ready = 1'b1;

  m3h_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .q_full        (q_full),
    .push          (push)
  );

  m3h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  m3h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed_we        (cfg_valid && cfg_ready),
    .seed_data      (cfg_seed),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

### rtl/m3h_front.sv
`timescale 1ns / 1ps

module m3h_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [m3h_pkg::WordW-1:0]     in_data_word,
  input  logic [m3h_pkg::CountW-1:0]    in_byte_count,
  input  logic                          in_last,
  input  logic                          q_full,
  output m3h_pkg::push_t                push
);

  logic [m3h_pkg::CountW-1:0] eff_count;
  logic [m3h_pkg::WordW-1:0]  masked;

  // Only the final beat may be short; counts above four mean a full word.
  always_comb begin
    if (!in_last || (in_byte_count inside {[3'd4:3'd7]})) begin
      eff_count = m3h_pkg::CountFull;
    end else begin
      eff_count = in_byte_count;
    end
  end

  always_comb begin
    case (eff_count)
      3'd0: masked = '0;
      3'd1: masked = {24'd0, in_data_word[7:0]};
      3'd2: masked = {16'd0, in_data_word[15:0]};
      3'd3: masked = {8'd0, in_data_word[23:0]};
      default: masked = in_data_word;
    endcase
  end

  assign in_stall        = q_full;
  assign push.en         = in_valid && !q_full;
  assign push.item.word  = masked;
  assign push.item.count = eff_count;
  assign push.item.last  = in_last;

endmodule

### rtl/m3h_queue.sv
`timescale 1ns / 1ps

module m3h_queue #(
  parameter int DEPTH = m3h_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  m3h_pkg::push_t  push,
  output logic            full,
  input  logic            pop,
  output m3h_pkg::qhead_t head
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  m3h_pkg::item_t  mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic            do_pop;

  assign full       = (fill_r == CntW'(DEPTH));
  assign head.valid = (fill_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push.en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.en && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push.en && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

### rtl/m3h_back.sv
`timescale 1ns / 1ps

module m3h_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      seed_we,
  input  logic [m3h_pkg::WordW-1:0] seed_data,
  input  m3h_pkg::qhead_t           head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [m3h_pkg::WordW-1:0] out_hash_value
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL1  = 7'b0000010,
    ST_MUL2  = 7'b0000100,
    ST_FOLD  = 7'b0001000,
    ST_FMIX1 = 7'b0010000,
    ST_FMIX2 = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [m3h_pkg::WordW-1:0]   seed_r, seed_nxt;
  logic                        in_key_r, in_key_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [m3h_pkg::WordW-1:0]   out_hash_r, out_hash_nxt;
  logic [m3h_pkg::WordW-1:0]   k_r, k_nxt;
  logic [m3h_pkg::WordW-1:0]   h_r, h_nxt;
  logic [m3h_pkg::WordW-1:0]   total_r, total_nxt;
  logic [m3h_pkg::CountW-1:0]  cnt_r, cnt_nxt;
  logic                        last_r, last_nxt;

  logic [m3h_pkg::WordW-1:0]   hx, hrot, mix_a, mix_b;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    hx    = h_r ^ k_r;
    hrot  = {hx[18:0], hx[31:19]};
    mix_a = h_r ^ total_r;
    mix_a = mix_a ^ (mix_a >> 16);
    mix_b = k_r ^ (k_r >> 13);
  end

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_we ? seed_data : seed_r;
    in_key_nxt    = in_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    k_nxt         = k_r;
    h_nxt         = h_r;
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          k_nxt      = head.item.word;
          cnt_nxt    = head.item.count;
          last_nxt   = head.item.last;
          in_key_nxt = 1'b1;
          // The first beat of a key starts from the seed as it is now.
          if (!in_key_r) begin
            h_nxt     = seed_r;
            total_nxt = '0;
          end
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        k_nxt     = k_r * m3h_pkg::MulC1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        k_nxt     = {k_r[16:0], k_r[31:17]} * m3h_pkg::MulC2;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        // A full word folds with rotate, times five and add; a tail only xors; an empty tail leaves h.
        if (cnt_r == m3h_pkg::CountFull) begin
          h_nxt = {hrot[29:0], 2'b00} + hrot + m3h_pkg::FoldN;
        end else if (cnt_r != '0) begin
          h_nxt = hx;
        end
        total_nxt = total_r + m3h_pkg::WordW'(cnt_r);
        state_nxt = last_r ? ST_FMIX1 : ST_IDLE;
      end
      ST_FMIX1: begin
        k_nxt     = mix_a * m3h_pkg::MixF1;
        state_nxt = ST_FMIX2;
      end
      ST_FMIX2: begin
        k_nxt     = mix_b * m3h_pkg::MixF2;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_hash_nxt  = k_r ^ (k_r >> 16);
          out_valid_nxt = 1'b1;
          in_key_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      in_key_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      in_key_r    <= in_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
    k_r        <= k_nxt;
    h_r        <= h_nxt;
    total_r    <= total_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
  end

endmodule

### rtl/m3h_checker.sv
`timescale 1ns / 1ps
`include "murmur3_32_hash_unit_macros.svh"

module m3h_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [m3h_pkg::WordW-1:0]  out_hash_value
);

  // Keys whose final beat went in but whose hash has not been taken yet.
  logic [7:0] pend_r, pend_nxt;
  logic       last_in, res_out;

  assign last_in = in_valid && !in_stall && in_last;
  assign res_out = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (last_in && !res_out) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!last_in && res_out) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `M3H_ASSERT_IMPL(a_result_has_key, clk, rst_n, out_valid, pend_r != 8'd0)
  `M3H_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_hash_value))
  `M3H_ASSERT_IMPL(a_no_result_idle, clk, rst_n, pend_r == 8'd0, !out_valid)

endmodule

bind murmur3_32_hash_unit m3h_checker u_m3h_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hash_value (out_hash_value)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 32;
  localparam int PhaseCount   = 8;
  localparam int PhaseBeats   = 240;

  typedef enum logic {RowBeat, RowSeed} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] word;
    logic [2:0]  count;
    logic        fin;
    logic        pinned;
    logic [31:0] hash;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_hash_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed;

  // Hand-typed hash that travels with a beat; replaces the computed one when set.
  logic        in_pinned;
  logic [31:0] in_pinned_hash;

  logic [31:0] seed_copy;
  logic [31:0] acc_hash;
  logic [31:0] acc_len;
  logic        key_open;
  logic [31:0] pending_hashes[$];

  int  error_count;
  int  beats_sent;
  int  cycles;
  int  rx_hold_len;
  bit  no_idle;

  stim_row_t directed_rows [20] = '{
    '{RowBeat, 32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h00000000},
    '{RowBeat, 32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'ha5a5a5a5, 3'd2, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'h00000000, 3'd5, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'h12345678, 3'd7, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'h00000000, 3'd7, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'h80000001, 3'd3, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'h87654321, 3'd4, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'hdeadbeef, 3'd6, 1'b1, 1'b0, 32'h0},
    '{RowSeed, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'h7fffffff, 3'd1, 1'b1, 1'b0, 32'h0},
    '{RowSeed, 32'h00000001, 3'd0, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'h00000000, 3'd1, 1'b1, 1'b0, 32'h0},
    '{RowBeat, 32'h0000ffff, 3'd2, 1'b0, 1'b0, 32'h0},
    '{RowBeat, 32'hffff0000, 3'd2, 1'b1, 1'b0, 32'h0}
  };

  murmur3_32_hash_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_seed      (cfg_seed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] scramble_word(logic [31:0] k);
    logic [31:0] t;
    t = k * m3h_pkg::MulC1;
    t = {t[16:0], t[31:17]};
    return t * m3h_pkg::MulC2;
  endfunction

  function automatic logic [31:0] finalize_hash(logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * m3h_pkg::MixF1;
    t = t ^ (t >> 13);
    t = t * m3h_pkg::MixF2;
    return t ^ (t >> 16);
  endfunction

  // Folds one accepted beat into the running key hash; a final beat queues the
  // finished hash and closes the key.
  task automatic absorb_beat(input logic [31:0] word, input logic [2:0] cnt,
                             input logic fin, input logic pin, input logic [31:0] pin_hash);
    logic [31:0] h;
    logic [2:0]  n;
    logic [31:0] mask;
    if (!key_open) begin
      acc_hash = seed_copy;
      acc_len  = 32'h0;
      key_open = 1'b1;
    end
    h = acc_hash;
    n = (!fin || cnt >= m3h_pkg::CountFull) ? m3h_pkg::CountFull : cnt;
    if (n == m3h_pkg::CountFull) begin
      h = h ^ scramble_word(word);
      h = {h[18:0], h[31:19]} * 32'd5 + m3h_pkg::FoldN;
    end else if (n != 3'd0) begin
      mask = (32'h1 << (8 * n)) - 32'h1;
      h = h ^ scramble_word(word & mask);
    end
    acc_len = acc_len + 32'(n);
    if (!fin) begin
      acc_hash = h;
    end else begin
      pending_hashes.push_back(pin ? pin_hash : finalize_hash(h ^ acc_len));
      key_open = 1'b0;
    end
  endtask

  // Input side and seed writes share one process so the predictor has a single writer.
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_copy = 32'h0;
      acc_hash  = 32'h0;
      acc_len   = 32'h0;
      key_open  = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_copy = cfg_seed;
      end
      if (in_valid && !in_stall) begin
        absorb_beat(in_data_word, in_byte_count, in_last, in_pinned, in_pinned_hash);
      end
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash beat with none expected: expected none, actual %h",
                 $time, out_hash_value);
        error_count++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_hash_value !== want) begin
          $display("%0t: hash_value mismatch: expected %h, actual %h",
                   $time, want, out_hash_value);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: a random hold before each beat (none while no_idle is set), or one long hold on request.
  initial begin : rx_side
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_len > 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(input logic [31:0] word, input logic [2:0] cnt, input logic fin,
                           input logic pin, input logic [31:0] pin_hash);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_word   <= word;
    in_byte_count  <= cnt;
    in_last        <= fin;
    in_pinned      <= pin;
    in_pinned_hash <= pin_hash;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Stops sending until every hash is back, then lets the pipeline settle.
  task automatic drain_hashes();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hashes.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h00000000;
    if (r < 16) return 32'hffffffff;
    return $urandom;
  endfunction

  // Mostly short keys, some medium, a few long; non-final counts are random
  // since the block ignores them.
  task automatic send_key();
    int r;
    int words;
    r = $urandom_range(0, 99);
    if (r < 70) words = $urandom_range(1, 6);
    else if (r < 92) words = $urandom_range(7, 20);
    else words = $urandom_range(21, 48);
    for (int i = 1; i < words; i++) begin
      send_beat(pick_word(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, 32'h0);
    end
    send_beat(pick_word(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, 32'h0);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_word   <= 32'h0;
    in_byte_count  <= 3'd0;
    in_last        <= 1'b0;
    in_pinned      <= 1'b0;
    in_pinned_hash <= 32'h0;
    cfg_valid      <= 1'b0;
    cfg_seed       <= 32'h0;
    error_count = 0;
    beats_sent  = 0;
    rx_hold_len = 0;
    no_idle     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowSeed) begin
        drain_hashes();
        write_seed(directed_rows[i].word);
      end else begin
        send_beat(directed_rows[i].word, directed_rows[i].count, directed_rows[i].fin,
                  directed_rows[i].pinned, directed_rows[i].hash);
      end
    end
    drain_hashes();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        3: write_seed(32'h00000000);
        5: write_seed(32'hffffffff);
        default: write_seed($urandom);
      endcase
      no_idle = (phase == 2);
      // Long result hold while beats keep coming, so the queue fills and in_stall rises.
      if (phase == 4) rx_hold_len = 400;
      while (beats_sent < 20 + (phase + 1) * PhaseBeats) send_key();
      drain_hashes();
    end

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
